[hdl/lant_pkg.sv]
// Shared types and constants of the multistate ant automaton.
package lant_pkg;

  localparam int unsigned SIDE = 256;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_STATE_COUNT   = 3'd0,
    CFG_TURN_RULES    = 3'd1,
    CFG_START_COLUMN  = 3'd2,
    CFG_START_ROW     = 3'd3,
    CFG_START_HEADING = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [4:0]  state_count;
    logic [31:0] turn_rules;
    logic [7:0]  start_column;
    logic [7:0]  start_row;
    logic [1:0]  start_heading;
  } cfg_t;

  localparam logic [4:0]  RST_STATE_COUNT   = 5'd2;
  localparam logic [31:0] RST_TURN_RULES    = 32'd13;
  localparam logic [7:0]  RST_START_COLUMN  = 8'd128;
  localparam logic [7:0]  RST_START_ROW     = 8'd128;
  localparam logic [1:0]  RST_START_HEADING = 2'd0;

endpackage

[hdl/lant_cfg.sv]
// Configuration register bank of the ant automaton.
module lant_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output lant_pkg::cfg_t      cfg_o
);
  import lant_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STATE_COUNT:   cfg_d.state_count   = cfg_data_i[4:0];
        CFG_TURN_RULES:    cfg_d.turn_rules    = cfg_data_i;
        CFG_START_COLUMN:  cfg_d.start_column  = cfg_data_i[7:0];
        CFG_START_ROW:     cfg_d.start_row     = cfg_data_i[7:0];
        CFG_START_HEADING: cfg_d.start_heading = cfg_data_i[1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.state_count   <= RST_STATE_COUNT;
      cfg_q.turn_rules    <= RST_TURN_RULES;
      cfg_q.start_column  <= RST_START_COLUMN;
      cfg_q.start_row     <= RST_START_ROW;
      cfg_q.start_heading <= RST_START_HEADING;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hdl/lant_cell_ram.sv]
// Cell colour memory: one write port, one registered read port.
module lant_cell_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

[hdl/lant_ctrl.sv]
// Ant sequencer: read-modify-write of the cell store, ant registers, result register.
module lant_ctrl #(
  parameter  int unsigned COLUMNS  = 256,
  parameter  int unsigned ROWS     = 256,
  localparam int unsigned EXT_COLS = (COLUMNS < 256) ? COLUMNS : 256,
  localparam int unsigned EXT_ROWS = (ROWS < 256) ? ROWS : 256,
  localparam int unsigned COL_W    = $clog2(EXT_COLS),
  localparam int unsigned ROW_W    = $clog2(EXT_ROWS),
  localparam int unsigned AW       = COL_W + ROW_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lant_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      opcode_i,
  input  logic [7:0]      read_column_i,
  input  logic [7:0]      read_row_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      ant_column_o,
  output logic [7:0]      ant_row_o,
  output logic [1:0]      ant_heading_o,
  output logic [7:0]      cell_column_o,
  output logic [7:0]      cell_row_o,
  output logic [3:0]      cell_colour_o,
  output logic            left_grid_o,
  output logic [31:0]     ticks_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [3:0]      mem_wdata_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [3:0]      mem_rdata_i
);
  import lant_pkg::*;

  localparam logic [8:0] EXT_COLS_W = 9'(EXT_COLS);
  localparam logic [8:0] EXT_ROWS_W = 9'(EXT_ROWS);

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [7:0]  col_q, col_d, row_q, row_d;
  logic [1:0]  hdg_q, hdg_d;
  logic        flag_q, flag_d;
  logic [31:0] tick_q, tick_d;

  op_e         op_q;
  logic [7:0]  rc_q, rr_q;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  o_col_q, o_row_q, o_ccol_q, o_crow_q;
  logic [1:0]  o_hdg_q;
  logic [3:0]  o_colour_q;
  logic        o_flag_q;
  logic [31:0] o_tick_q;
  logic [7:0]  o_ccol_d, o_crow_d;
  logic [3:0]  o_colour_d;

  logic        accept, exec_go;
  logic        ant_in, new_in, rd_in;
  logic [1:0]  new_hdg, turn;
  logic [4:0]  nxt;
  logic [3:0]  nxt_colour;
  logic [7:0]  mv_col, mv_row;

  function automatic logic in_grid(logic [7:0] c, logic [7:0] r);
    return ({1'b0, c} < EXT_COLS_W) && ({1'b0, r} < EXT_ROWS_W);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [7:0] c, logic [7:0] r);
    return {c[COL_W-1:0], r[ROW_W-1:0]};
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign mem_re_o    = accept;
  assign mem_raddr_o = (op_e'(opcode_i) == OP_READ) ? cell_addr(read_column_i, read_row_i)
                                                    : cell_addr(col_q, row_q);

  // step arithmetic on the colour just read
  assign ant_in     = in_grid(col_q, row_q);
  assign rd_in      = in_grid(rc_q, rr_q);
  assign turn       = cfg_i.turn_rules[{mem_rdata_i, 1'b0} +: 2];
  assign new_hdg    = hdg_q + turn;
  assign nxt        = {1'b0, mem_rdata_i} + 5'd1;
  assign nxt_colour = ((nxt >= cfg_i.state_count) || nxt[4]) ? 4'd0 : nxt[3:0];

  always_comb begin
    mv_col = col_q;
    mv_row = row_q;
    unique case (new_hdg)
      2'd0: mv_col = col_q - 8'd1;
      2'd1: mv_row = row_q - 8'd1;
      2'd2: mv_col = col_q + 8'd1;
      2'd3: mv_row = row_q + 8'd1;
      default: mv_col = col_q;
    endcase
  end
  assign new_in = in_grid(mv_col, mv_row);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    col_d       = col_q;
    row_d       = row_q;
    hdg_d       = hdg_q;
    flag_d      = flag_q;
    tick_d      = tick_q;
    o_ccol_d    = 8'd0;
    o_crow_d    = 8'd0;
    o_colour_d  = 4'd0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cell_addr(col_q, row_q);
    mem_wdata_o = nxt_colour;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = 4'd0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          unique case (op_q)
            OP_STEP: begin
              tick_d   = tick_q + 32'd1;
              o_ccol_d = col_q;
              o_crow_d = row_q;
              if (flag_q || !ant_in) begin
                flag_d = 1'b1;
              end else begin
                mem_we_o   = 1'b1;
                o_colour_d = nxt_colour;
                hdg_d      = new_hdg;
                col_d      = mv_col;
                row_d      = mv_row;
                if ((new_hdg == 2'd0 && col_q == 8'd0) ||
                    (new_hdg == 2'd1 && row_q == 8'd0) || !new_in) begin
                  flag_d = 1'b1;
                end
              end
            end
            OP_READ: begin
              o_ccol_d   = rc_q;
              o_crow_d   = rr_q;
              o_colour_d = rd_in ? mem_rdata_i : 4'd0;
            end
            OP_RESTART: begin
              col_d   = cfg_i.start_column;
              row_d   = cfg_i.start_row;
              hdg_d   = cfg_i.start_heading;
              flag_d  = 1'b0;
              tick_d  = 32'd0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= RST_START_COLUMN;
      row_q       <= RST_START_ROW;
      hdg_q       <= RST_START_HEADING;
      flag_q      <= 1'b0;
      tick_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      hdg_q       <= hdg_d;
      flag_q      <= flag_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(opcode_i);
      rc_q <= read_column_i;
      rr_q <= read_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      o_col_q    <= col_d;
      o_row_q    <= row_d;
      o_hdg_q    <= hdg_d;
      o_ccol_q   <= o_ccol_d;
      o_crow_q   <= o_crow_d;
      o_colour_q <= o_colour_d;
      o_flag_q   <= flag_d;
      o_tick_q   <= tick_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ant_column_o  = o_col_q;
  assign ant_row_o     = o_row_q;
  assign ant_heading_o = o_hdg_q;
  assign cell_column_o = o_ccol_q;
  assign cell_row_o    = o_crow_q;
  assign cell_colour_o = o_colour_q;
  assign left_grid_o   = o_flag_q;
  assign ticks_o       = o_tick_q;

endmodule

[hdl/multistate_ant_automaton_step.sv]
// Top level of the multistate ant automaton: config bank, sequencer and cell memory.
// The opcode and the cell read are registered when a word is accepted; the result is
// registered when the output is free, and no new word is taken until then.
// Reset and every restart run a clearing pass of one cell a cycle over all the memory's
//   2**(clog2(min(COLUMNS,256)) + clog2(min(ROWS,256))) cells (65536 by default),
//   during which no word is taken; configuration writes are taken at any time.
module multistate_ant_automaton_step #(
  parameter int unsigned COLUMNS = 256,
  parameter int unsigned ROWS    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  read_column_i,
  input  logic [7:0]  read_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  ant_column_o,
  output logic [7:0]  ant_row_o,
  output logic [1:0]  ant_heading_o,
  output logic [7:0]  cell_column_o,
  output logic [7:0]  cell_row_o,
  output logic [3:0]  cell_colour_o,
  output logic        left_grid_o,
  output logic [31:0] ticks_o
);
  import lant_pkg::*;

  localparam int unsigned EXT_COLS = (COLUMNS < 256) ? COLUMNS : 256;
  localparam int unsigned EXT_ROWS = (ROWS < 256) ? ROWS : 256;
  localparam int unsigned AW       = $clog2(EXT_COLS) + $clog2(EXT_ROWS);

  cfg_t          cfg;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [3:0]    mem_wdata, mem_rdata;

  lant_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lant_cell_ram #(
    .AW (AW),
    .DW (4)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lant_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .read_column_i (read_column_i),
    .read_row_i    (read_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ant_column_o  (ant_column_o),
    .ant_row_o     (ant_row_o),
    .ant_heading_o (ant_heading_o),
    .cell_column_o (cell_column_o),
    .cell_row_o    (cell_row_o),
    .cell_colour_o (cell_colour_o),
    .left_grid_o   (left_grid_o),
    .ticks_o       (ticks_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

endmodule
